@@ rtl/pcg_pkg.sv @@
// Package for the PCG32 generator with bounded draws.
// Holds the LCG constants, command codes, sequencer widths and the XSH-RR output function.
// Depends on nothing; every other file of the block uses it by scoped names.
`default_nettype none

package pcg_pkg;

    localparam int STATE_W = 64;
    localparam int DRAW_W  = 32;
    localparam int PROD_W  = 2 * DRAW_W;
    localparam int FRAC_SHIFT = 8;

    localparam logic [STATE_W-1:0] PCG_MULT = 64'd6364136223846793005;
    localparam logic [STATE_W-1:0] PCG_INC  = 64'd1442695040888963407;
    // State after seeding with zero: step from zero gives INC, then one more step.
    localparam logic [STATE_W-1:0] PCG_RESET_STATE = 64'(PCG_INC * PCG_MULT + PCG_INC);

    localparam int XSH_SHIFT   = 18;
    localparam int MIX_SHIFT   = 27;
    localparam int ROT_SHIFT   = 59;

    localparam int DIV_STEPS = DRAW_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    typedef logic [1:0] cmd_t;
    localparam cmd_t CMD_RESEED = 2'd0;
    localparam cmd_t CMD_RAW    = 2'd1;
    localparam cmd_t CMD_RANGE  = 2'd2;
    localparam cmd_t CMD_FRAC   = 2'd3;

    // XSH-RR output permutation of the old state.
    function automatic logic [DRAW_W-1:0] pcg_output(input logic [STATE_W-1:0] s);
        logic [DRAW_W-1:0]   mixed;
        logic [4:0]          rot;
        logic [2*DRAW_W-1:0] both;
        mixed = DRAW_W'((s ^ (s >> XSH_SHIFT)) >> MIX_SHIFT);
        rot   = s[STATE_W-1:ROT_SHIFT];
        both  = {mixed, mixed} >> rot;
        return both[DRAW_W-1:0];
    endfunction

endpackage

`default_nettype wire

@@ rtl/pcg_mul.sv @@
// Shared registered 32 by 32 multiplier of the PCG32 block.
// Loads a new product when enabled and holds it otherwise; uses pcg_pkg.
`default_nettype none

module pcg_mul (
    input  wire logic                        clk,
    input  wire logic                        en,
    input  wire logic [pcg_pkg::DRAW_W-1:0]  a,
    input  wire logic [pcg_pkg::DRAW_W-1:0]  b,
    output logic      [pcg_pkg::PROD_W-1:0]  p
);

    logic [pcg_pkg::PROD_W-1:0] p_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg <= pcg_pkg::PROD_W'(a) * pcg_pkg::PROD_W'(b);
        end
    end

    assign p = p_reg;

endmodule

`default_nettype wire

@@ rtl/pcg_rem.sv @@
// Bit-serial restoring remainder unit, one quotient bit per cycle.
// Used for the rejection threshold of the bounded draw; uses pcg_pkg.
`default_nettype none

module pcg_rem (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [pcg_pkg::DRAW_W-1:0]  dividend,
    input  wire logic [pcg_pkg::DRAW_W-1:0]  divisor,
    output logic                             done,
    output logic      [pcg_pkg::DRAW_W-1:0]  remainder
);

    logic [pcg_pkg::DIV_CNT_W-1:0] count_reg, count_next;
    logic                          done_reg, done_next;
    logic [pcg_pkg::DRAW_W-1:0]    dvd_reg, dvd_next;
    logic [pcg_pkg::DRAW_W-1:0]    dsr_reg, dsr_next;
    logic [pcg_pkg::DRAW_W-1:0]    rem_reg, rem_next;
    logic [pcg_pkg::DRAW_W:0]      trial;

    always_comb
    begin
        count_next = count_reg;
        done_next  = 1'b0;
        dvd_next   = dvd_reg;
        dsr_next   = dsr_reg;
        rem_next   = rem_reg;
        trial      = {rem_reg, dvd_reg[pcg_pkg::DRAW_W-1]};
        if (start)
        begin
            count_next = pcg_pkg::DIV_CNT_W'(pcg_pkg::DIV_STEPS);
            dvd_next   = dividend;
            dsr_next   = divisor;
            rem_next   = '0;
        end
        else if (count_reg != '0)
        begin
            // The partial remainder stays below the divisor, so one subtract suffices.
            if (trial >= {1'b0, dsr_reg})
            begin
                rem_next = pcg_pkg::DRAW_W'(trial - {1'b0, dsr_reg});
            end
            else
            begin
                rem_next = trial[pcg_pkg::DRAW_W-1:0];
            end
            dvd_next   = {dvd_reg[pcg_pkg::DRAW_W-2:0], 1'b0};
            count_next = count_reg - pcg_pkg::DIV_CNT_W'(1);
            done_next  = (count_reg == pcg_pkg::DIV_CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

@@ rtl/pcg32_random_with_range.sv @@
// PCG32 (XSH-RR) generator with raw, bounded (Lemire) and Q0.24 fraction draws.
// Each command runs the state step through the M0..M3 states; a reseed runs it twice, and a
// bounded draw adds a multiply by the bound, the threshold divide when the low half of that
// product falls below the bound (at most once per command), and a new step per rejected redraw.
// Throughput: one command at a time, the next taken as soon as the result is offered, unless a
// stalled earlier result still holds the sequencer. Reset is asynchronous, active low.
`default_nettype none

module pcg32_random_with_range (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    // Seed register write channel.
    input  wire logic                                 seed_valid,
    output logic                                      seed_ready,
    input  wire logic [pcg_pkg::STATE_W-1:0]          seed_value,
    // Command channel.
    input  wire logic                                 cmd_valid,
    output logic                                      cmd_stall,
    input  wire logic [1:0]                           command,
    input  wire logic [pcg_pkg::DRAW_W-1:0]           range_low,
    input  wire logic [pcg_pkg::DRAW_W-1:0]           range_high,
    // Result channel.
    output logic                                      result_valid,
    input  wire logic                                 result_stall,
    output logic      [pcg_pkg::DRAW_W-1:0]           value
);

    // Sequencer codes. The M0..M3 states form the state step: three partial products
    // of the 64-bit LCG multiply go through the shared multiplier, one per cycle.
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_M0   = 4'd1;
    localparam logic [3:0] S_M1   = 4'd2;
    localparam logic [3:0] S_M2   = 4'd3;
    localparam logic [3:0] S_M3   = 4'd4;
    localparam logic [3:0] S_SEED = 4'd5;
    localparam logic [3:0] S_BM   = 4'd6;
    localparam logic [3:0] S_BW   = 4'd7;
    localparam logic [3:0] S_DIV  = 4'd8;
    localparam logic [3:0] S_OUT  = 4'd9;

    localparam int H = pcg_pkg::DRAW_W;

    logic [3:0]                    state_reg, state_next;
    logic [pcg_pkg::STATE_W-1:0]   gen_reg, gen_next;
    logic [pcg_pkg::STATE_W-1:0]   seed_reg, seed_next;
    logic [pcg_pkg::STATE_W-1:0]   acc_reg, acc_next;
    logic                          phase_reg, phase_next;
    logic                          t_valid_reg, t_valid_next;
    logic                          out_valid_reg, out_valid_next;
    pcg_pkg::cmd_t                 cmd_reg, cmd_next;
    logic [H-1:0]                  low_reg, low_next;
    logic [H-1:0]                  bound_reg, bound_next;
    logic [H-1:0]                  x_reg, x_next;
    logic [H-1:0]                  t_reg, t_next;
    logic [H-1:0]                  res_reg, res_next;
    logic [H-1:0]                  out_reg, out_next;

    logic                          mul_en;
    logic [H-1:0]                  mul_a, mul_b;
    logic [pcg_pkg::PROD_W-1:0]    mul_p;
    logic                          div_start;
    logic                          div_done;
    logic [H-1:0]                  div_rem;
    logic                          cmd_beat;
    logic [pcg_pkg::STATE_W-1:0]   upper_part;

    pcg_mul u_mul (
        .clk (clk),
        .en  (mul_en),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    // The threshold (2^32 - bound) mod bound is worked out at most once per bounded command.
    pcg_rem u_rem (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (H'(0) - bound_reg),
        .divisor   (bound_reg),
        .done      (div_done),
        .remainder (div_rem)
    );

    assign seed_ready   = 1'b1;
    assign cmd_stall    = (state_reg != S_IDLE);
    assign cmd_beat     = cmd_valid && !cmd_stall;
    assign result_valid = out_valid_reg;
    assign value        = out_reg;

    // A cross product only reaches the upper half of the 64-bit result.
    assign upper_part = {mul_p[H-1:0], {H{1'b0}}};

    // Operand selection for the shared multiplier.
    always_comb
    begin
        mul_en = 1'b1;
        mul_a  = '0;
        mul_b  = '0;
        case (state_reg)
            S_M0:
            begin
                mul_a = gen_reg[H-1:0];
                mul_b = pcg_pkg::PCG_MULT[H-1:0];
            end
            S_M1:
            begin
                mul_a = gen_reg[pcg_pkg::STATE_W-1:H];
                mul_b = pcg_pkg::PCG_MULT[H-1:0];
            end
            S_M2:
            begin
                mul_a = gen_reg[H-1:0];
                mul_b = pcg_pkg::PCG_MULT[pcg_pkg::STATE_W-1:H];
            end
            S_BM:
            begin
                mul_a = x_reg;
                mul_b = bound_reg;
            end
            default:
            begin
                // Hold the product, which the bounded path still needs while dividing.
                mul_en = 1'b0;
            end
        endcase
    end

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        gen_next       = gen_reg;
        seed_next      = seed_reg;
        acc_next       = acc_reg;
        phase_next     = phase_reg;
        t_valid_next   = t_valid_reg;
        cmd_next       = cmd_reg;
        low_next       = low_reg;
        bound_next     = bound_reg;
        x_next         = x_reg;
        t_next         = t_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        div_start      = 1'b0;

        if (seed_valid && seed_ready)
        begin
            seed_next = seed_value;
        end

        // The result register drains independently of the sequencer.
        if (out_valid_reg && !result_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_beat)
                begin
                    cmd_next     = command;
                    low_next     = range_low;
                    bound_next   = range_high - range_low;
                    t_valid_next = 1'b0;
                    phase_next   = 1'b0;
                    // Each draw's output comes from the state before it is stepped.
                    x_next       = pcg_pkg::pcg_output(gen_reg);
                    if (command == pcg_pkg::CMD_RESEED)
                    begin
                        gen_next = '0;
                    end
                    state_next = S_M0;
                end
            end
            S_M0:
            begin
                state_next = S_M1;
            end
            S_M1:
            begin
                acc_next   = mul_p + pcg_pkg::PCG_INC;
                state_next = S_M2;
            end
            S_M2:
            begin
                acc_next   = acc_reg + upper_part;
                state_next = S_M3;
            end
            S_M3:
            begin
                gen_next = acc_reg + upper_part;
                case (cmd_reg)
                    pcg_pkg::CMD_RESEED:
                    begin
                        if (phase_reg)
                        begin
                            res_next   = '0;
                            state_next = S_OUT;
                        end
                        else
                        begin
                            state_next = S_SEED;
                        end
                    end
                    pcg_pkg::CMD_RAW:
                    begin
                        res_next   = x_reg;
                        state_next = S_OUT;
                    end
                    pcg_pkg::CMD_RANGE:
                    begin
                        state_next = S_BM;
                    end
                    default:
                    begin
                        res_next   = x_reg >> pcg_pkg::FRAC_SHIFT;
                        state_next = S_OUT;
                    end
                endcase
            end
            S_SEED:
            begin
                gen_next   = gen_reg + seed_reg;
                phase_next = 1'b1;
                state_next = S_M0;
            end
            S_BM:
            begin
                state_next = S_BW;
            end
            S_BW:
            begin
                // The low half of x * bound decides acceptance.
                if (t_valid_reg)
                begin
                    if (mul_p[H-1:0] < t_reg)
                    begin
                        x_next     = pcg_pkg::pcg_output(gen_reg);
                        state_next = S_M0;
                    end
                    else
                    begin
                        res_next   = low_reg + mul_p[pcg_pkg::PROD_W-1:H];
                        state_next = S_OUT;
                    end
                end
                else if ((bound_reg != '0) && (mul_p[H-1:0] < bound_reg))
                begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
                else
                begin
                    res_next   = low_reg + mul_p[pcg_pkg::PROD_W-1:H];
                    state_next = S_OUT;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    t_next       = div_rem;
                    t_valid_next = 1'b1;
                    if (mul_p[H-1:0] < div_rem)
                    begin
                        x_next     = pcg_pkg::pcg_output(gen_reg);
                        state_next = S_M0;
                    end
                    else
                    begin
                        res_next   = low_reg + mul_p[pcg_pkg::PROD_W-1:H];
                        state_next = S_OUT;
                    end
                end
            end
            S_OUT:
            begin
                // Wait here only while an earlier beat still sits in the result register.
                if (!out_valid_reg || !result_stall)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            gen_reg       <= pcg_pkg::PCG_RESET_STATE;
            seed_reg      <= '0;
            phase_reg     <= 1'b0;
            t_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            gen_reg       <= gen_next;
            seed_reg      <= seed_next;
            phase_reg     <= phase_next;
            t_valid_reg   <= t_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg   <= acc_next;
        cmd_reg   <= cmd_next;
        low_reg   <= low_next;
        bound_reg <= bound_next;
        x_reg     <= x_next;
        t_reg     <= t_next;
        res_reg   <= res_next;
        out_reg   <= out_next;
    end

    // A command beat always starts the sequencer.
    a_beat_starts: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_beat |=> (state_reg != S_IDLE))
        else $error("command beat did not leave idle");

    // The remainder unit is only started by a bounded draw with a non-zero bound.
    a_div_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> ((cmd_reg == pcg_pkg::CMD_RANGE) && (bound_reg != '0)))
        else $error("threshold divide started outside a bounded draw");

    // The rejection threshold is always below the bound.
    a_thresh_below: assert property (@(posedge clk) disable iff (!rst_n)
        t_valid_reg |-> (t_reg < bound_reg))
        else $error("rejection threshold not below bound");

    // A reseed answers with zero.
    a_reseed_zero: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_OUT) && (cmd_reg == pcg_pkg::CMD_RESEED)) |-> (res_reg == '0))
        else $error("reseed result not zero");

    // A unit fraction leaves the top byte clear.
    a_frac_top: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_OUT) && (cmd_reg == pcg_pkg::CMD_FRAC)) |-> (res_reg[H-1:H-8] == '0))
        else $error("fraction result has upper bits set");

endmodule

`default_nettype wire

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for pcg32_random_with_range: a directed table, then random commands.
// Results are compared against an in-bench PCG32 predictor; depends on the RTL and pcg_pkg only.

module tb;

    // The predictor keeps its own copies of the generator constants, so that a wrong
    // constant in the package cannot hide behind a matching prediction.
    localparam logic [63:0] LCG_MULT = 64'd6364136223846793005;
    localparam logic [63:0] LCG_INC  = 64'd1442695040888963407;

    localparam int    CLK_HALF_NS = 6;
    localparam int    RESET_CYCLES = 7;
    localparam int    DRAIN_CYCLES = 8;     // settle time before a seed write
    localparam int    TAIL_CYCLES  = 64;    // watch for stray results at the end
    localparam int    HOLD_CYCLES  = 250;   // long receiver hold-off
    localparam int    PHASE_ITEMS  = 100;
    localparam longint TIMEOUT_NS  = 12_000_000;  // time limit for the whole run

    // One row of the directed table. Where has_want is set, the expected draw is typed in;
    // otherwise the predictor supplies it.
    typedef struct packed {
        pcg_pkg::cmd_t op;
        logic [31:0]   lo;
        logic [31:0]   hi;
        logic          has_want;
        logic [31:0]   want;
    } stim_row_t;

    localparam int DIR_ROWS = 23;

    logic clk;
    logic rst_n;

    logic                         seed_valid;
    logic                         seed_ready;
    logic [pcg_pkg::STATE_W-1:0]  seed_value;

    logic                         cmd_valid;
    logic                         cmd_stall;
    logic [1:0]                   command;
    logic [pcg_pkg::DRAW_W-1:0]   range_low;
    logic [pcg_pkg::DRAW_W-1:0]   range_high;

    logic                         result_valid;
    logic                         result_stall;
    logic [pcg_pkg::DRAW_W-1:0]   value;

    // Predictor state: the generator state and the seed register as the block should hold them.
    logic [63:0] gen_state;
    logic [63:0] seed_reg;

    // Draws still owed by the block, oldest first.
    logic [31:0] pending_draws [$];
    logic [31:0] front_draw;

    int fail_count    = 0;
    int send_idle_pct = 0;
    int stall_pct     = 0;
    bit hold_req      = 1'b0;
    int hold_left     = 0;

    // The directed part. It covers every command, the field extremes, a bound of zero,
    // a bound of one (which must always return the low end), a low end above the high
    // end so that the span wraps, the widest span, spans just above half the range where
    // roughly every other draw is rejected, and garbage on the range fields for commands
    // that ignore them.
    stim_row_t directed_rows [DIR_ROWS] = '{
        '{pcg_pkg::CMD_RAW,    32'h0000_0000, 32'h0000_0000, 1'b0, 32'h0},
        '{pcg_pkg::CMD_FRAC,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 32'h0},
        '{pcg_pkg::CMD_RESEED, 32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000},
        '{pcg_pkg::CMD_RAW,    32'h5555_5555, 32'hAAAA_AAAA, 1'b0, 32'h0},
        '{pcg_pkg::CMD_RANGE,  32'h0000_0007, 32'h0000_0007, 1'b1, 32'h0000_0007},
        '{pcg_pkg::CMD_RANGE,  32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000},
        '{pcg_pkg::CMD_RANGE,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF},
        '{pcg_pkg::CMD_RANGE,  32'h0000_1234, 32'h0000_1235, 1'b1, 32'h0000_1234},
        '{pcg_pkg::CMD_RANGE,  32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 32'hFFFF_FFFF},
        '{pcg_pkg::CMD_RANGE,  32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 32'h0},
        '{pcg_pkg::CMD_RANGE,  32'h0000_0001, 32'h0000_0000, 1'b0, 32'h0},
        '{pcg_pkg::CMD_RANGE,  32'h8000_0000, 32'h0000_0000, 1'b0, 32'h0},
        '{pcg_pkg::CMD_RANGE,  32'h0000_0000, 32'h8000_0001, 1'b0, 32'h0},
        '{pcg_pkg::CMD_RANGE,  32'h0000_0000, 32'h8000_0001, 1'b0, 32'h0},
        '{pcg_pkg::CMD_RANGE,  32'h1000_0000, 32'h9000_0003, 1'b0, 32'h0},
        '{pcg_pkg::CMD_RANGE,  32'h0000_0010, 32'h0000_0020, 1'b0, 32'h0},
        '{pcg_pkg::CMD_RANGE,  32'hF000_0000, 32'h0000_0010, 1'b0, 32'h0},
        '{pcg_pkg::CMD_RANGE,  32'h0000_0000, 32'h0000_0003, 1'b0, 32'h0},
        '{pcg_pkg::CMD_RESEED, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 1'b1, 32'h0000_0000},
        '{pcg_pkg::CMD_FRAC,   32'h0000_0000, 32'h0000_0000, 1'b0, 32'h0},
        '{pcg_pkg::CMD_RAW,    32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 32'h0},
        '{pcg_pkg::CMD_FRAC,   32'h1234_5678, 32'h8765_4321, 1'b0, 32'h0},
        '{pcg_pkg::CMD_RANGE,  32'hFFFF_FFF0, 32'hFFFF_FFFF, 1'b0, 32'h0}
    };

    pcg32_random_with_range dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .seed_valid   (seed_valid),
        .seed_ready   (seed_ready),
        .seed_value   (seed_value),
        .cmd_valid    (cmd_valid),
        .cmd_stall    (cmd_stall),
        .command      (command),
        .range_low    (range_low),
        .range_high   (range_high),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .value        (value)
    );

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // One PCG32 draw: the output is taken from the old state (xorshift, then a rotate
    // right by the top five bits), and the state then takes one LCG step.
    function automatic logic [31:0] next_draw();
        logic [63:0] old_state;
        logic [31:0] mixed;
        logic [4:0]  rot;
        old_state = gen_state;
        gen_state = old_state * LCG_MULT + LCG_INC;
        mixed = 32'((old_state ^ (old_state >> 18)) >> 27);
        rot   = old_state[63:59];
        if (rot == 5'd0)
            return mixed;
        return (mixed >> rot) | (mixed << (6'd32 - {1'b0, rot}));
    endfunction

    // Reseed: clear, step, fold in the seed register, step again.
    function automatic void reseed_state();
        gen_state = '0;
        void'(next_draw());
        gen_state = gen_state + seed_reg;
        void'(next_draw());
    endfunction

    // Lemire's multiply-and-reject draw over [lo, hi), with the span taken modulo 2^32.
    // The threshold is only worked out when the low half of the product falls below the
    // span, and a span of zero takes one draw and returns the low end.
    function automatic logic [31:0] ranged_draw(input logic [31:0] lo, input logic [31:0] hi);
        logic [31:0] span;
        logic [31:0] thresh;
        logic [63:0] prod;
        span = hi - lo;
        prod = 64'(next_draw()) * 64'(span);
        if (span != 32'd0 && prod[31:0] < span) begin
            thresh = (32'd0 - span) % span;
            while (prod[31:0] < thresh)
                prod = 64'(next_draw()) * 64'(span);
        end
        return lo + prod[63:32];
    endfunction

    function automatic logic [31:0] predict_draw(input pcg_pkg::cmd_t op,
                                                 input logic [31:0] lo,
                                                 input logic [31:0] hi);
        logic [31:0] draw;
        case (op)
            pcg_pkg::CMD_RESEED:
            begin
                reseed_state();
                draw = 32'd0;
            end
            pcg_pkg::CMD_RAW:   draw = next_draw();
            pcg_pkg::CMD_RANGE: draw = ranged_draw(lo, hi);
            default:            draw = next_draw() >> 8;    // Q0.24 fraction, top byte clear
        endcase
        return draw;
    endfunction

    // ------------------------------------------------------------------
    // Clock, receiver and result checking
    // ------------------------------------------------------------------

    initial
    begin
        clk = 1'b0;
        forever #(CLK_HALF_NS) clk = ~clk;
    end

    // The receiver stalls at random at the current rate, except during a requested
    // hold-off, which it counts out itself so that the sender can keep offering beats.
    initial
    begin
        result_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left    = hold_left - 1;
                result_stall <= 1'b1;
            end
            else
                result_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Each result beat is matched against the oldest owed draw.
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_draws.size() == 0)
            begin
                $error("value: expected nothing, got %h", value);
                fail_count++;
            end
            else
            begin
                front_draw = pending_draws.pop_front();
                if (value !== front_draw)
                begin
                    $error("value: expected %h, got %h", front_draw, value);
                    fail_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    // Offers one command beat, after a random number of idle cycles at the current rate.
    // Valid is raised at a falling edge and held, with its payload, until a rising edge
    // finds the stall low. The draw is predicted at that edge; a typed-in value, where
    // the row gives one, replaces the prediction as the expectation.
    task automatic send_cmd(input pcg_pkg::cmd_t op, input logic [31:0] lo,
                            input logic [31:0] hi, input bit has_want,
                            input logic [31:0] want);
        logic [31:0] guess;
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(negedge clk);
        end
        cmd_valid  <= 1'b1;
        command    <= op;
        range_low  <= lo;
        range_high <= hi;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        guess = predict_draw(op, lo, hi);
        pending_draws.push_back(has_want ? want : guess);
    endtask

    // Drops valid at the next falling edge, so that a held beat is not taken twice.
    task automatic stop_sending();
        @(negedge clk);
        cmd_valid <= 1'b0;
    endtask

    task automatic wait_for_drain();
        while (pending_draws.size() != 0)
            @(posedge clk);
    endtask

    // The seed register is only written with the block idle: every owed draw back and a
    // short settling time after the last one.
    task automatic write_seed(input logic [63:0] seed);
        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
        seed_valid <= 1'b1;
        seed_value <= seed;
        @(posedge clk);
        while (!seed_ready)
            @(posedge clk);
        seed_reg = seed;
        @(negedge clk);
        seed_valid <= 1'b0;
    endtask

    // Random commands. Bounded draws make up nearly half and are spread over small spans
    // (zero included), spans just above half the range where rejection is heavy, wrapped
    // spans with the low end above the high end, and fully random ends.
    task automatic random_cmd(output pcg_pkg::cmd_t op, output logic [31:0] lo,
                              output logic [31:0] hi);
        int pick;
        pick = $urandom_range(99);
        lo   = $urandom;
        hi   = $urandom;
        if (pick < 12)
            op = pcg_pkg::CMD_RESEED;
        else if (pick < 35)
            op = pcg_pkg::CMD_RAW;
        else if (pick < 55)
            op = pcg_pkg::CMD_FRAC;
        else
        begin
            op = pcg_pkg::CMD_RANGE;
            case ($urandom_range(4))
                0: hi = lo + $urandom_range(16);
                1: hi = lo + 32'h8000_0000 + $urandom_range(8);
                2: hi = lo - $urandom_range(1, 16);
                default: ;
            endcase
        end
    endtask

    // One random phase: a fresh seed, a reseed to bring it in, then random commands.
    // Halfway through, the sender pauses until every owed draw has come back. Where
    // squeeze is set, the receiver holds off for a long stretch a quarter of the way in
    // while the sender keeps offering beats, so that the block fills and stalls its input.
    task automatic run_phase(input logic [63:0] seed, input int idle_pct, input int stall_rate,
                             input bit squeeze);
        pcg_pkg::cmd_t op;
        logic [31:0]   lo;
        logic [31:0]   hi;
        write_seed(seed);
        send_idle_pct = idle_pct;
        stall_pct     = stall_rate;
        send_cmd(pcg_pkg::CMD_RESEED, $urandom, $urandom, 1'b0, 32'h0);
        for (int i = 0; i < PHASE_ITEMS; i++)
        begin
            if (squeeze && i == PHASE_ITEMS / 4)
                hold_req = 1'b1;
            if (i == PHASE_ITEMS / 2)
            begin
                stop_sending();
                wait_for_drain();
            end
            random_cmd(op, lo, hi);
            send_cmd(op, lo, hi, 1'b0, 32'h0);
        end
        stop_sending();
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial
    begin
        rst_n      = 1'b0;
        seed_valid = 1'b0;
        seed_value = '0;
        cmd_valid  = 1'b0;
        command    = pcg_pkg::CMD_RESEED;
        range_low  = '0;
        range_high = '0;

        // After reset the seed register is zero and the state is that of a zero seed.
        seed_reg = 64'd0;
        reseed_state();

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed rows run back to back with the reset seed.
        for (int r = 0; r < DIR_ROWS; r++)
            send_cmd(directed_rows[r].op, directed_rows[r].lo, directed_rows[r].hi,
                     directed_rows[r].has_want, directed_rows[r].want);
        stop_sending();

        // Random phases: no idling with the long hold-off, idle sender, stalling receiver,
        // both, and a closing stretch with no idling. Seeds cover both extremes.
        run_phase(64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 1'b1);
        run_phase({$urandom, $urandom}, 49, 0, 1'b0);
        run_phase(64'h0000_0000_0000_0000, 0, 49, 1'b0);
        run_phase(64'h8000_0000_0000_0001, 16, 16, 1'b0);
        run_phase({$urandom, $urandom}, 0, 0, 1'b0);

        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("pcg32_random_with_range verification clean");
        else
            $display("pcg32_random_with_range verification failed");
        $finish;
    end

    // Safety net against a hung handshake.
    initial
    begin
        #(TIMEOUT_NS);
        $display("pcg32_random_with_range verification failed");
        $finish;
    end

endmodule
